/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge, off while reset is held.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on the rising edge, off while reset is held.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/dctv1_pkg.sv */
`default_nettype none

package dctv1_pkg;

	localparam int WIN_BITS     = 24;
	localparam int WIN_IDX_W    = $clog2(WIN_BITS);
	localparam int NUM_CODES    = 112;
	localparam int MAX_CODE_LEN = 16;
	localparam int EOB_LEN      = 4;
	localparam int ESC_LEN      = 6;
	localparam int ESC_RUN_BITS = 6;
	localparam int ESC_LVL_BITS = 12;

	localparam logic [EOB_LEN-1:0] EOB_CODE = 4'b0110;
	localparam logic [6:0]         ESC_SLOT = 7'd15;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EOB     = 3'd1;
	localparam logic [2:0] ST_MORE    = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_UNSUP   = 3'd4;

	typedef struct packed {
		logic [WIN_BITS-1:0] bit_window;
		logic [4:0]          bits_valid;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         run_length;
		logic signed [11:0] coeff_level;
		logic [4:0]         bits_used;
	} rsp_t;

	typedef struct packed {
		logic        hit;
		logic [4:0]  len;
		logic        escape;
		logic [4:0]  run;
		logic [5:0]  level;
	} match_t;

	typedef struct packed {
		logic [15:0] code;
		logic [4:0]  len;
		logic [6:0]  slot;
	} vlc_code_t;

	typedef struct packed {
		logic [4:0] run;
		logic [5:0] level;
	} run_level_t;

	localparam vlc_code_t CODES [NUM_CODES] = '{
		'{16'h02, 5'd2, 7'd0},   '{16'h02, 5'd3, 7'd1},   '{16'h06, 5'd3, 7'd2},
		'{16'h07, 5'd4, 7'd4},   '{16'h05, 5'd5, 7'd3},   '{16'h07, 5'd5, 7'd5},
		'{16'h06, 5'd5, 7'd7},   '{16'h1C, 5'd5, 7'd11},  '{16'h1D, 5'd5, 7'd16},
		'{16'h06, 5'd6, 7'd6},   '{16'h07, 5'd6, 7'd8},   '{16'h05, 5'd6, 7'd17},
		'{16'h04, 5'd6, 7'd24},  '{16'h01, 5'd6, 7'd15},  '{16'h79, 5'd7, 7'd18},
		'{16'h7A, 5'd7, 7'd20},  '{16'h07, 5'd7, 7'd12},  '{16'h05, 5'd7, 7'd13},
		'{16'h78, 5'd7, 7'd14},  '{16'h06, 5'd7, 7'd9},   '{16'h04, 5'd7, 7'd10},
		'{16'h7B, 5'd7, 7'd32},  '{16'h7C, 5'd7, 7'd33},  '{16'h26, 5'd8, 7'd19},
		'{16'h21, 5'd8, 7'd21},  '{16'h25, 5'd8, 7'd22},  '{16'h24, 5'd8, 7'd23},
		'{16'h27, 5'd8, 7'd25},  '{16'hFC, 5'd8, 7'd26},  '{16'hFD, 5'd8, 7'd27},
		'{16'hFA, 5'd8, 7'd48},  '{16'hFB, 5'd8, 7'd49},  '{16'hFE, 5'd8, 7'd50},
		'{16'hFF, 5'd8, 7'd51},  '{16'h23, 5'd8, 7'd34},  '{16'h22, 5'd8, 7'd35},
		'{16'h20, 5'd8, 7'd36},  '{16'h04, 5'd9, 7'd28},  '{16'h05, 5'd9, 7'd29},
		'{16'h07, 5'd9, 7'd30},  '{16'h0D, 5'd10, 7'd31}, '{16'h0C, 5'd10, 7'd37},
		'{16'h1C, 5'd12, 7'd38}, '{16'h12, 5'd12, 7'd39}, '{16'h1E, 5'd12, 7'd40},
		'{16'h15, 5'd12, 7'd41}, '{16'h11, 5'd12, 7'd42}, '{16'h1F, 5'd12, 7'd43},
		'{16'h1A, 5'd12, 7'd44}, '{16'h19, 5'd12, 7'd45}, '{16'h17, 5'd12, 7'd46},
		'{16'h16, 5'd12, 7'd47}, '{16'h16, 5'd13, 7'd52}, '{16'h15, 5'd13, 7'd53},
		'{16'h14, 5'd13, 7'd54}, '{16'h13, 5'd13, 7'd55}, '{16'h12, 5'd13, 7'd56},
		'{16'h11, 5'd13, 7'd57}, '{16'h10, 5'd13, 7'd58}, '{16'h1F, 5'd13, 7'd59},
		'{16'h1E, 5'd13, 7'd60}, '{16'h1D, 5'd13, 7'd61}, '{16'h1C, 5'd13, 7'd62},
		'{16'h1B, 5'd13, 7'd63}, '{16'h1F, 5'd14, 7'd64}, '{16'h1E, 5'd14, 7'd65},
		'{16'h1D, 5'd14, 7'd66}, '{16'h1C, 5'd14, 7'd67}, '{16'h1B, 5'd14, 7'd68},
		'{16'h1A, 5'd14, 7'd69}, '{16'h19, 5'd14, 7'd70}, '{16'h18, 5'd14, 7'd71},
		'{16'h17, 5'd14, 7'd72}, '{16'h16, 5'd14, 7'd73}, '{16'h15, 5'd14, 7'd74},
		'{16'h14, 5'd14, 7'd75}, '{16'h13, 5'd14, 7'd76}, '{16'h12, 5'd14, 7'd77},
		'{16'h11, 5'd14, 7'd78}, '{16'h10, 5'd14, 7'd79}, '{16'h18, 5'd15, 7'd80},
		'{16'h17, 5'd15, 7'd81}, '{16'h16, 5'd15, 7'd82}, '{16'h15, 5'd15, 7'd83},
		'{16'h14, 5'd15, 7'd84}, '{16'h13, 5'd15, 7'd85}, '{16'h12, 5'd15, 7'd86},
		'{16'h11, 5'd15, 7'd87}, '{16'h10, 5'd15, 7'd88}, '{16'h1F, 5'd15, 7'd89},
		'{16'h1E, 5'd15, 7'd90}, '{16'h1D, 5'd15, 7'd91}, '{16'h1C, 5'd15, 7'd92},
		'{16'h1B, 5'd15, 7'd93}, '{16'h1A, 5'd15, 7'd94}, '{16'h19, 5'd15, 7'd95},
		'{16'h13, 5'd16, 7'd96}, '{16'h12, 5'd16, 7'd97}, '{16'h11, 5'd16, 7'd98},
		'{16'h10, 5'd16, 7'd99}, '{16'h14, 5'd16, 7'd100}, '{16'h1A, 5'd16, 7'd101},
		'{16'h19, 5'd16, 7'd102}, '{16'h18, 5'd16, 7'd103}, '{16'h17, 5'd16, 7'd104},
		'{16'h16, 5'd16, 7'd105}, '{16'h15, 5'd16, 7'd106}, '{16'h1F, 5'd16, 7'd107},
		'{16'h1E, 5'd16, 7'd108}, '{16'h1D, 5'd16, 7'd109}, '{16'h1C, 5'd16, 7'd110},
		'{16'h1B, 5'd16, 7'd111}
	};

	localparam run_level_t PAIRS [NUM_CODES] = '{
		'{5'd0, 6'd1},  '{5'd1, 6'd1},  '{5'd0, 6'd2},  '{5'd2, 6'd1},
		'{5'd0, 6'd3},  '{5'd3, 6'd1},  '{5'd4, 6'd1},  '{5'd1, 6'd2},
		'{5'd5, 6'd1},  '{5'd6, 6'd1},  '{5'd7, 6'd1},  '{5'd0, 6'd4},
		'{5'd2, 6'd2},  '{5'd8, 6'd1},  '{5'd9, 6'd1},  '{5'd0, 6'd0},
		'{5'd0, 6'd5},  '{5'd0, 6'd6},  '{5'd1, 6'd3},  '{5'd3, 6'd2},
		'{5'd10, 6'd1}, '{5'd11, 6'd1}, '{5'd12, 6'd1}, '{5'd13, 6'd1},
		'{5'd0, 6'd7},  '{5'd1, 6'd4},  '{5'd2, 6'd3},  '{5'd4, 6'd2},
		'{5'd5, 6'd2},  '{5'd14, 6'd1}, '{5'd15, 6'd1}, '{5'd16, 6'd1},
		'{5'd0, 6'd8},  '{5'd0, 6'd9},  '{5'd0, 6'd10}, '{5'd0, 6'd11},
		'{5'd1, 6'd5},  '{5'd2, 6'd4},  '{5'd3, 6'd3},  '{5'd4, 6'd3},
		'{5'd6, 6'd2},  '{5'd7, 6'd2},  '{5'd8, 6'd2},  '{5'd17, 6'd1},
		'{5'd18, 6'd1}, '{5'd19, 6'd1}, '{5'd20, 6'd1}, '{5'd21, 6'd1},
		'{5'd0, 6'd12}, '{5'd0, 6'd13}, '{5'd0, 6'd14}, '{5'd0, 6'd15},
		'{5'd1, 6'd6},  '{5'd1, 6'd7},  '{5'd2, 6'd5},  '{5'd3, 6'd4},
		'{5'd5, 6'd3},  '{5'd9, 6'd2},  '{5'd10, 6'd2}, '{5'd22, 6'd1},
		'{5'd23, 6'd1}, '{5'd24, 6'd1}, '{5'd25, 6'd1}, '{5'd26, 6'd1},
		'{5'd0, 6'd16}, '{5'd0, 6'd17}, '{5'd0, 6'd18}, '{5'd0, 6'd19},
		'{5'd0, 6'd20}, '{5'd0, 6'd21}, '{5'd0, 6'd22}, '{5'd0, 6'd23},
		'{5'd0, 6'd24}, '{5'd0, 6'd25}, '{5'd0, 6'd26}, '{5'd0, 6'd27},
		'{5'd0, 6'd28}, '{5'd0, 6'd29}, '{5'd0, 6'd30}, '{5'd0, 6'd31},
		'{5'd0, 6'd32}, '{5'd0, 6'd33}, '{5'd0, 6'd34}, '{5'd0, 6'd35},
		'{5'd0, 6'd36}, '{5'd0, 6'd37}, '{5'd0, 6'd38}, '{5'd0, 6'd39},
		'{5'd0, 6'd40}, '{5'd1, 6'd8},  '{5'd1, 6'd9},  '{5'd1, 6'd10},
		'{5'd1, 6'd11}, '{5'd1, 6'd12}, '{5'd1, 6'd13}, '{5'd1, 6'd14},
		'{5'd1, 6'd15}, '{5'd1, 6'd16}, '{5'd1, 6'd17}, '{5'd1, 6'd18},
		'{5'd6, 6'd3},  '{5'd11, 6'd2}, '{5'd12, 6'd2}, '{5'd13, 6'd2},
		'{5'd14, 6'd2}, '{5'd15, 6'd2}, '{5'd16, 6'd2}, '{5'd27, 6'd1},
		'{5'd28, 6'd1}, '{5'd29, 6'd1}, '{5'd30, 6'd1}, '{5'd31, 6'd1}
	};

endpackage

`default_nettype wire

/* src/dct_coeff_table_one_vlc_decoder.sv */
`default_nettype none

// Intra AC coefficient VLC decoder for DCT coefficient table one. Each req transfer
// carries the next 24 stream bits (first bit at the MSB) and how many of them are
// present; each rsp transfer returns status, run_length, signed coeff_level and
// bits_used, the number of bits to advance the stream. Status reads 0 ok, 1 end of
// block (bits_used 4), 2 need more bits, 3 invalid code, 4 escape unsupported (an
// escape while mpeg1_mode is set); outside ok, run_length and coeff_level are zero,
// and bits_used is zero unless end of block. Throughput is one window per clock
// while rsp is not stalled: the window is captured in an input register, decoded by
// one parallel match of all table codes, and the result lands in an output register
// that drives rsp. Stalls on rsp back up through both registers; the input side
// keeps taking windows as long as a register is free.
// mpeg1_mode is written through cfg_wr_en/cfg_wr_data and must only change while
// no window is in flight.
module dct_coeff_table_one_vlc_decoder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic            cfg_wr_data,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire dctv1_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output dctv1_pkg::rsp_t      rsp
);

`include "assert_macros.svh"

	logic            mpeg1_mode_q;
	logic            valid_s1;
	logic            valid_s2;
	dctv1_pkg::req_t req_s1;
	dctv1_pkg::rsp_t rsp_s2;
	dctv1_pkg::rsp_t rsp_dec;
	logic            load_s2;
	logic            load_s1;

	// advance the output stage whenever it is empty or its transfer completes
	assign load_s2   = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || load_s2;
	assign load_s1   = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpeg1_mode_q <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mpeg1_mode_q <= cfg_wr_data;
			end
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload: hold unless the stage advances
	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= req;
		end
		if (load_s2 && valid_s1) begin
			rsp_s2 <= rsp_dec;
		end
	end

	dctv1_decode u_decode (
		.mpeg1_mode (mpeg1_mode_q),
		.req        (req_s1),
		.rsp        (rsp_dec)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// a decoded window moves into the free output stage
	`AST_NEXT(a_s1_to_s2, clk, arst_n, valid_s1 && load_s2, valid_s2)
	// only ok results carry run and level
	`AST_IMPL(a_zero_fields, clk, arst_n, valid_s2 && (rsp_s2.status != dctv1_pkg::ST_OK),
		(rsp_s2.run_length == 6'd0) && (rsp_s2.coeff_level == 12'sd0))
	// an ok code spends at least a two-bit code and sign, at most the window
	`AST_IMPL(a_ok_used, clk, arst_n, valid_s2 && (rsp_s2.status == dctv1_pkg::ST_OK),
		(rsp_s2.bits_used >= 5'd3) && (rsp_s2.bits_used <= 5'(dctv1_pkg::WIN_BITS)))
	// unsupported escape only in MPEG-1 mode
	`AST_IMPL(a_unsup_mode, clk, arst_n, valid_s2 && (rsp_s2.status == dctv1_pkg::ST_UNSUP),
		mpeg1_mode_q)

endmodule

`default_nettype wire

/* src/dctv1_match.sv */
`default_nettype none

// Parallel prefix match of the first stream bits against every table code.
module dctv1_match (
	input  wire logic [dctv1_pkg::MAX_CODE_LEN-1:0] prefix,
	output dctv1_pkg::match_t                       match
);

	logic       len_hit  [dctv1_pkg::MAX_CODE_LEN+1];
	logic [6:0] len_slot [dctv1_pkg::MAX_CODE_LEN+1];
	logic [6:0] slot;

	always_comb begin
		for (int l = 0; l <= dctv1_pkg::MAX_CODE_LEN; l++) begin
			len_hit[l]  = 1'b0;
			len_slot[l] = '0;
		end
		// codes of one length differ, so at most one fires per length
		for (int k = 0; k < dctv1_pkg::NUM_CODES; k++) begin
			if ((prefix >> (5'(dctv1_pkg::MAX_CODE_LEN) - dctv1_pkg::CODES[k].len))
					== dctv1_pkg::CODES[k].code) begin
				len_hit[dctv1_pkg::CODES[k].len]  = 1'b1;
				len_slot[dctv1_pkg::CODES[k].len] = len_slot[dctv1_pkg::CODES[k].len]
					| dctv1_pkg::CODES[k].slot;
			end
		end
	end

	// shortest matching length wins
	always_comb begin
		match.hit = 1'b0;
		match.len = '0;
		slot      = '0;
		for (int l = dctv1_pkg::MAX_CODE_LEN; l >= 2; l--) begin
			if (len_hit[l]) begin
				match.hit = 1'b1;
				match.len = 5'(l);
				slot      = len_slot[l];
			end
		end
		match.escape = (slot == dctv1_pkg::ESC_SLOT);
		match.run    = dctv1_pkg::PAIRS[slot].run;
		match.level  = dctv1_pkg::PAIRS[slot].level;
	end

endmodule

`default_nettype wire

/* src/dctv1_decode.sv */
`default_nettype none

// Turns one bit window into status, run, level and bit count.
module dctv1_decode (
	input  wire logic            mpeg1_mode,
	input  wire dctv1_pkg::req_t req,
	output dctv1_pkg::rsp_t      rsp
);

	localparam int W = dctv1_pkg::WIN_BITS;

	dctv1_pkg::match_t             match;
	logic [4:0]                    valid;
	logic [4:0]                    plain_used;
	logic [dctv1_pkg::WIN_IDX_W-1:0] sign_idx;
	logic [11:0]                   mag;

	dctv1_match u_match (
		.prefix (req.bit_window[W-1 -: dctv1_pkg::MAX_CODE_LEN]),
		.match  (match)
	);

	assign valid      = (req.bits_valid > 5'(W)) ? 5'(W) : req.bits_valid;
	assign plain_used = match.len + 5'd1;
	assign sign_idx   = dctv1_pkg::WIN_IDX_W'(W - 1) - dctv1_pkg::WIN_IDX_W'(match.len);
	assign mag        = {6'd0, match.level};

	always_comb begin
		rsp.status      = dctv1_pkg::ST_MORE;
		rsp.run_length  = '0;
		rsp.coeff_level = '0;
		rsp.bits_used   = '0;
		priority if (valid < 5'(dctv1_pkg::EOB_LEN)) begin
			rsp.status = dctv1_pkg::ST_MORE;
		end else if (req.bit_window[W-1 -: dctv1_pkg::EOB_LEN] == dctv1_pkg::EOB_CODE) begin
			rsp.status    = dctv1_pkg::ST_EOB;
			rsp.bits_used = 5'(dctv1_pkg::EOB_LEN);
		end else if (!match.hit || (match.len > valid)) begin
			rsp.status = (valid < 5'(dctv1_pkg::MAX_CODE_LEN)) ? dctv1_pkg::ST_MORE
				: dctv1_pkg::ST_INVALID;
		end else if (match.escape) begin
			priority if (valid < 5'(dctv1_pkg::ESC_LEN + dctv1_pkg::ESC_RUN_BITS)) begin
				rsp.status = dctv1_pkg::ST_MORE;
			end else if (mpeg1_mode) begin
				rsp.status = dctv1_pkg::ST_UNSUP;
			end else if (valid < 5'(dctv1_pkg::ESC_LEN + dctv1_pkg::ESC_RUN_BITS
					+ dctv1_pkg::ESC_LVL_BITS)) begin
				rsp.status = dctv1_pkg::ST_MORE;
			end else begin
				rsp.status      = dctv1_pkg::ST_OK;
				rsp.run_length  = req.bit_window[W-1-dctv1_pkg::ESC_LEN -: dctv1_pkg::ESC_RUN_BITS];
				rsp.coeff_level = $signed(req.bit_window[W-1-dctv1_pkg::ESC_LEN
					-dctv1_pkg::ESC_RUN_BITS -: dctv1_pkg::ESC_LVL_BITS]);
				rsp.bits_used   = 5'(dctv1_pkg::ESC_LEN + dctv1_pkg::ESC_RUN_BITS
					+ dctv1_pkg::ESC_LVL_BITS);
			end
		end else if (valid < plain_used) begin
			rsp.status = dctv1_pkg::ST_MORE;
		end else begin
			rsp.status      = dctv1_pkg::ST_OK;
			rsp.run_length  = {1'b0, match.run};
			rsp.coeff_level = $signed(req.bit_window[sign_idx] ? (~mag + 12'd1) : mag);
			rsp.bits_used   = plain_used;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_dct_coeff_table_one_vlc_decoder.sv */
`timescale 1ns / 100ps

module tb_dct_coeff_table_one_vlc_decoder;

	localparam int NUM_VLC      = 112;
	localparam int LONG_HOLD    = 60;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 120;

	typedef enum int {IDLE_NONE, IDLE_NORMAL, IDLE_HEAVY} idle_style_t;

	typedef struct packed {
		int pattern;
		int nbits;
		int slot;
	} vlc_entry_t;

	typedef struct packed {
		int zero_run;
		int magnitude;
	} run_level_entry_t;

	// Table one codes: pattern (right aligned), code length, run/level slot.
	localparam vlc_entry_t CODE_TABLE [NUM_VLC] = '{
		'{'h02, 2, 0},   '{'h02, 3, 1},   '{'h06, 3, 2},   '{'h07, 4, 4},
		'{'h05, 5, 3},   '{'h07, 5, 5},   '{'h06, 5, 7},   '{'h1C, 5, 11},
		'{'h1D, 5, 16},  '{'h06, 6, 6},   '{'h07, 6, 8},   '{'h05, 6, 17},
		'{'h04, 6, 24},  '{'h01, 6, 15},  '{'h79, 7, 18},  '{'h7A, 7, 20},
		'{'h07, 7, 12},  '{'h05, 7, 13},  '{'h78, 7, 14},  '{'h06, 7, 9},
		'{'h04, 7, 10},  '{'h7B, 7, 32},  '{'h7C, 7, 33},  '{'h26, 8, 19},
		'{'h21, 8, 21},  '{'h25, 8, 22},  '{'h24, 8, 23},  '{'h27, 8, 25},
		'{'hFC, 8, 26},  '{'hFD, 8, 27},  '{'hFA, 8, 48},  '{'hFB, 8, 49},
		'{'hFE, 8, 50},  '{'hFF, 8, 51},  '{'h23, 8, 34},  '{'h22, 8, 35},
		'{'h20, 8, 36},  '{'h04, 9, 28},  '{'h05, 9, 29},  '{'h07, 9, 30},
		'{'h0D, 10, 31}, '{'h0C, 10, 37}, '{'h1C, 12, 38}, '{'h12, 12, 39},
		'{'h1E, 12, 40}, '{'h15, 12, 41}, '{'h11, 12, 42}, '{'h1F, 12, 43},
		'{'h1A, 12, 44}, '{'h19, 12, 45}, '{'h17, 12, 46}, '{'h16, 12, 47},
		'{'h16, 13, 52}, '{'h15, 13, 53}, '{'h14, 13, 54}, '{'h13, 13, 55},
		'{'h12, 13, 56}, '{'h11, 13, 57}, '{'h10, 13, 58}, '{'h1F, 13, 59},
		'{'h1E, 13, 60}, '{'h1D, 13, 61}, '{'h1C, 13, 62}, '{'h1B, 13, 63},
		'{'h1F, 14, 64}, '{'h1E, 14, 65}, '{'h1D, 14, 66}, '{'h1C, 14, 67},
		'{'h1B, 14, 68}, '{'h1A, 14, 69}, '{'h19, 14, 70}, '{'h18, 14, 71},
		'{'h17, 14, 72}, '{'h16, 14, 73}, '{'h15, 14, 74}, '{'h14, 14, 75},
		'{'h13, 14, 76}, '{'h12, 14, 77}, '{'h11, 14, 78}, '{'h10, 14, 79},
		'{'h18, 15, 80}, '{'h17, 15, 81}, '{'h16, 15, 82}, '{'h15, 15, 83},
		'{'h14, 15, 84}, '{'h13, 15, 85}, '{'h12, 15, 86}, '{'h11, 15, 87},
		'{'h10, 15, 88}, '{'h1F, 15, 89}, '{'h1E, 15, 90}, '{'h1D, 15, 91},
		'{'h1C, 15, 92}, '{'h1B, 15, 93}, '{'h1A, 15, 94}, '{'h19, 15, 95},
		'{'h13, 16, 96}, '{'h12, 16, 97}, '{'h11, 16, 98}, '{'h10, 16, 99},
		'{'h14, 16, 100}, '{'h1A, 16, 101}, '{'h19, 16, 102}, '{'h18, 16, 103},
		'{'h17, 16, 104}, '{'h16, 16, 105}, '{'h15, 16, 106}, '{'h1F, 16, 107},
		'{'h1E, 16, 108}, '{'h1D, 16, 109}, '{'h1C, 16, 110}, '{'h1B, 16, 111}
	};

	// Run and magnitude per slot; the escape slot carries no pair of its own.
	localparam run_level_entry_t LEVEL_TABLE [NUM_VLC] = '{
		'{0, 1},  '{1, 1},  '{0, 2},  '{2, 1},  '{0, 3},  '{3, 1},  '{4, 1},  '{1, 2},
		'{5, 1},  '{6, 1},  '{7, 1},  '{0, 4},  '{2, 2},  '{8, 1},  '{9, 1},  '{0, 0},
		'{0, 5},  '{0, 6},  '{1, 3},  '{3, 2},  '{10, 1}, '{11, 1}, '{12, 1}, '{13, 1},
		'{0, 7},  '{1, 4},  '{2, 3},  '{4, 2},  '{5, 2},  '{14, 1}, '{15, 1}, '{16, 1},
		'{0, 8},  '{0, 9},  '{0, 10}, '{0, 11}, '{1, 5},  '{2, 4},  '{3, 3},  '{4, 3},
		'{6, 2},  '{7, 2},  '{8, 2},  '{17, 1}, '{18, 1}, '{19, 1}, '{20, 1}, '{21, 1},
		'{0, 12}, '{0, 13}, '{0, 14}, '{0, 15}, '{1, 6},  '{1, 7},  '{2, 5},  '{3, 4},
		'{5, 3},  '{9, 2},  '{10, 2}, '{22, 1}, '{23, 1}, '{24, 1}, '{25, 1}, '{26, 1},
		'{0, 16}, '{0, 17}, '{0, 18}, '{0, 19}, '{0, 20}, '{0, 21}, '{0, 22}, '{0, 23},
		'{0, 24}, '{0, 25}, '{0, 26}, '{0, 27}, '{0, 28}, '{0, 29}, '{0, 30}, '{0, 31},
		'{0, 32}, '{0, 33}, '{0, 34}, '{0, 35}, '{0, 36}, '{0, 37}, '{0, 38}, '{0, 39},
		'{0, 40}, '{1, 8},  '{1, 9},  '{1, 10}, '{1, 11}, '{1, 12}, '{1, 13}, '{1, 14},
		'{1, 15}, '{1, 16}, '{1, 17}, '{1, 18}, '{6, 3},  '{11, 2}, '{12, 2}, '{13, 2},
		'{14, 2}, '{15, 2}, '{16, 2}, '{27, 1}, '{28, 1}, '{29, 1}, '{30, 1}, '{31, 1}
	};

	// Predicts each decode at the req transfer and checks rsp transfers in order.
	class coeff_scoreboard;
		bit              mpeg1;
		int              errors;
		int              compared;
		int              status_seen [5];
		dctv1_pkg::req_t window_log [$];
		dctv1_pkg::rsp_t expected_results [$];

		function void set_mode(bit m);
			mpeg1 = m;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function dctv1_pkg::rsp_t predict_decode(dctv1_pkg::req_t r);
			dctv1_pkg::rsp_t  o;
			logic [23:0]      w;
			logic [11:0]      lvl;
			int               avail;
			int               len;
			int               k;
			int               hit;
			run_level_entry_t pair;

			o = '0;
			o.status = dctv1_pkg::ST_MORE;
			w = r.bit_window;
			avail = (r.bits_valid > 24) ? 24 : int'(r.bits_valid);
			if (avail < dctv1_pkg::EOB_LEN)
				return o;
			if (w[23:20] == dctv1_pkg::EOB_CODE) begin
				o.status = dctv1_pkg::ST_EOB;
				o.bits_used = 5'(dctv1_pkg::EOB_LEN);
				return o;
			end
			hit = -1;
			for (len = 2; len <= dctv1_pkg::MAX_CODE_LEN && hit < 0; len++) begin
				if (avail < len)
					return o;
				for (k = 0; k < NUM_VLC; k++)
					if (CODE_TABLE[k].nbits == len && CODE_TABLE[k].pattern == int'(w >> (24 - len)))
						hit = k;
			end
			if (hit < 0) begin
				o.status = dctv1_pkg::ST_INVALID;
				return o;
			end
			len = CODE_TABLE[hit].nbits;
			if (CODE_TABLE[hit].slot == int'(dctv1_pkg::ESC_SLOT)) begin
				if (avail < len + 6)
					return o;
				if (mpeg1) begin
					o.status = dctv1_pkg::ST_UNSUP;
					return o;
				end
				if (avail < len + 18)
					return o;
				o.status = dctv1_pkg::ST_OK;
				o.run_length = w[23 - len -: 6];
				o.coeff_level = w[17 - len -: 12];
				o.bits_used = 5'(len + 18);
			end else begin
				if (avail < len + 1)
					return o;
				pair = LEVEL_TABLE[CODE_TABLE[hit].slot];
				lvl = 12'(pair.magnitude);
				if (w[23 - len])
					lvl = -lvl;
				o.status = dctv1_pkg::ST_OK;
				o.run_length = 6'(pair.zero_run);
				o.coeff_level = lvl;
				o.bits_used = 5'(len + 1);
			end
			return o;
		endfunction

		function void note_window(dctv1_pkg::req_t r);
			window_log.push_back(r);
			expected_results.push_back(predict_decode(r));
		endfunction

		function void check_result(dctv1_pkg::rsp_t got);
			dctv1_pkg::rsp_t want;
			dctv1_pkg::req_t src;

			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status %0d run %0d level %0d used %0d",
					$time, got.status, got.run_length, got.coeff_level, got.bits_used);
				return;
			end
			want = expected_results.pop_front();
			src = window_log.pop_front();
			compared++;
			if (want.status < 5)
				status_seen[want.status]++;
			if (got.status !== want.status || got.run_length !== want.run_length ||
			    got.coeff_level !== want.coeff_level || got.bits_used !== want.bits_used) begin
				errors++;
				$display("%0t: window %h valid %0d: expected st %0d run %0d lvl %0d used %0d,",
					$time, src.bit_window, src.bits_valid, want.status, want.run_length,
					want.coeff_level, want.bits_used);
				$display("%0t:   actual st %0d run %0d lvl %0d used %0d", $time,
					got.status, got.run_length, got.coeff_level, got.bits_used);
			end
		endfunction
	endclass

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            cfg_wr_en   = 1'b0;
	logic            cfg_wr_data = 1'b0;
	logic            req_valid   = 1'b0;
	logic            req_ready;
	dctv1_pkg::req_t req_item    = '0;
	logic            rsp_valid;
	logic            rsp_ready   = 1'b0;
	dctv1_pkg::rsp_t rsp_item;

	coeff_scoreboard sb = new();

	idle_style_t idle_style = IDLE_NORMAL;
	logic        hold_req   = 1'b0;
	bit          hold_done;
	int          hold_left;
	int          stall_left;
	int          cycle_count;
	int          sent;
	int          mode_writes;

	dct_coeff_table_one_vlc_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req_item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp_item)
	);

	always #6 clk = ~clk;

	// Length of the next idle stretch: mostly none or short, now and then long.
	function automatic int pick_gap(idle_style_t style);
		int roll;

		roll = $urandom_range(0, 99);
		case (style)
			IDLE_NONE: return 0;
			IDLE_NORMAL: begin
				if (roll < 55)
					return 0;
				if (roll < 90)
					return $urandom_range(1, 3);
				return $urandom_range(8, 30);
			end
			default: begin
				if (roll < 25)
					return 0;
				if (roll < 75)
					return $urandom_range(1, 4);
				return $urandom_range(10, 40);
			end
		endcase
	endfunction

	function automatic dctv1_pkg::req_t window_of(logic [23:0] w, logic [4:0] n);
		dctv1_pkg::req_t r;

		r.bit_window = w;
		r.bits_valid = n;
		return r;
	endfunction

	// Build one random window. Most are well-formed codes with random content so
	// the sign, escape and length checks get exercised; the rest are escape codes,
	// end of block, long zero prefixes that match nothing, and raw noise.
	function automatic dctv1_pkg::req_t pick_window();
		dctv1_pkg::req_t r;
		logic [23:0]     w;
		logic [5:0]      esc_run;
		logic [11:0]     esc_lvl;
		int              kind;
		int              k;
		int              len;
		int              need;
		int              roll;

		kind = $urandom_range(0, 99);
		w = 24'($urandom);
		need = 24;
		if (kind < 55) begin
			k = $urandom_range(0, NUM_VLC - 1);
			len = CODE_TABLE[k].nbits;
			w = (24'(CODE_TABLE[k].pattern) << (24 - len)) |
				(w & ((24'd1 << (24 - len)) - 24'd1));
			need = (CODE_TABLE[k].slot == int'(dctv1_pkg::ESC_SLOT)) ? 24 : len + 1;
		end else if (kind < 67) begin
			esc_run = ($urandom_range(0, 3) == 0) ? 6'h3F : 6'($urandom);
			case ($urandom_range(0, 4))
				0: esc_lvl = 12'h800;
				1: esc_lvl = 12'h7FF;
				2: esc_lvl = 12'h000;
				default: esc_lvl = 12'($urandom);
			endcase
			w = {6'b000001, esc_run, esc_lvl};
		end else if (kind < 74) begin
			w = {dctv1_pkg::EOB_CODE, w[19:0]};
			need = dctv1_pkg::EOB_LEN;
		end else if (kind < 82) begin
			// Twelve or more leading zeros match no code.
			w = w >> $urandom_range(12, 24);
			need = dctv1_pkg::MAX_CODE_LEN;
		end else begin
			return window_of(w, 5'($urandom));
		end
		roll = $urandom_range(0, 9);
		if (roll < 7)
			return window_of(w, 5'($urandom_range(need, 24)));
		if (roll == 7)
			return window_of(w, 5'($urandom_range(25, 31)));
		return window_of(w, 5'($urandom_range(0, need - 1)));
	endfunction

	// Offer one window and hold it until the transfer, then log the prediction.
	task automatic send_window(input dctv1_pkg::req_t r);
		req_item <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_window(r);
		sent++;
	endtask

	task automatic idle_sender();
		int n;

		n = pick_gap(idle_style);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every decode has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write mpeg1_mode only with nothing in flight, and switch the idling style.
	task automatic start_phase(input bit mode, input idle_style_t style);
		drain();
		idle_style <= style;
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_mode(mode);
		mode_writes++;
	endtask

	task automatic random_phase(input int count, input bit with_hold);
		int i;

		for (i = 0; i < count; i++) begin
			// Ask the receiver for a long hold and stream back to back into it,
			// so both pipeline registers fill and req_ready drops.
			if (with_hold && i == 40)
				hold_req <= 1'b1;
			// Pause once mid-phase until every result is home.
			if (with_hold && i == 80)
				drain();
			send_window(pick_window());
			if (!(with_hold && i >= 40 && i < 70))
				idle_sender();
		end
	endtask

	// Receiver: random short and long stalls, one long hold on request.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			stall_left = pick_gap(idle_style);
			rsp_ready <= (stall_left == 0);
		end
	end

	// Check every rsp transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp_item);
	end

	// Give up on a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// MPEG-2 mode: directed corners first.
		start_phase(1'b0, IDLE_NORMAL);
		send_window(window_of(24'h800000, 5'd0));    // nothing valid
		send_window(window_of(24'h600000, 5'd3));    // too short to rule out end of block
		send_window(window_of(24'h600000, 5'd4));    // end of block
		send_window(window_of(24'h800000, 5'd2));    // shortest code, sign missing
		send_window(window_of(24'h800000, 5'd3));    // shortest code, positive
		send_window(window_of(24'hA00000, 5'd31));   // count above window, negative
		send_window(window_of(24'h001B80, 5'd17));   // longest code, negative
		send_window(window_of(24'h001B80, 5'd16));   // longest code, sign missing
		send_window(window_of(24'h000000, 5'd24));   // no code matches
		send_window(window_of(24'h000000, 5'd15));   // no match yet, under 16 bits
		send_window(window_of(24'hFFFFFF, 5'd24));
		send_window(window_of({6'b000001, 6'h3F, 12'h7FF}, 5'd24));
		send_window(window_of({6'b000001, 6'h00, 12'h800}, 5'd24));
		send_window(window_of({6'b000001, 6'h01, 12'h000}, 5'd24));
		send_window(window_of({6'b000001, 6'h2A, 12'hFFF}, 5'd23));
		send_window(window_of({6'b000001, 6'h15, 12'h001}, 5'd12));
		idle_sender();
		random_phase(PHASE_ITEMS, 1'b1);

		// MPEG-1 mode: escapes become unsupported once the run is present.
		start_phase(1'b1, IDLE_NONE);
		send_window(window_of({6'b000001, 6'h3F, 12'h7FF}, 5'd11));
		send_window(window_of({6'b000001, 6'h3F, 12'h7FF}, 5'd12));
		send_window(window_of({6'b000001, 6'h00, 12'h800}, 5'd24));
		send_window(window_of(24'h6FFFFF, 5'd24));
		send_window(window_of(24'hA00000, 5'd3));
		random_phase(PHASE_ITEMS, 1'b0);

		start_phase(1'b0, IDLE_HEAVY);
		random_phase(PHASE_ITEMS, 1'b0);

		start_phase(1'b1, IDLE_NORMAL);
		random_phase(PHASE_ITEMS, 1'b0);

		drain();
		$display("Decoded %0d of %0d windows over %0d mode writes, one %0d-cycle output hold.",
			sb.compared, sent, mode_writes, LONG_HOLD);
		$display("Statuses: %0d ok, %0d end of block, %0d need more, %0d invalid, %0d unsup.",
			sb.status_seen[dctv1_pkg::ST_OK], sb.status_seen[dctv1_pkg::ST_EOB],
			sb.status_seen[dctv1_pkg::ST_MORE], sb.status_seen[dctv1_pkg::ST_INVALID],
			sb.status_seen[dctv1_pkg::ST_UNSUP]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
